// ===== sv/kvt_pkg.sv =====
package kvt_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 64;
  localparam int unsigned KEY_BITS_DEF    = 16;
  localparam int unsigned KEY_W           = 16;
  localparam int unsigned TYPE_W          = 3;
  localparam int unsigned VALUE_W         = 64;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_FIND  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } mem_cmd_t;

  typedef struct packed {
    logic               table_full;
    logic [VALUE_W-1:0] read_value;
    logic               found;
  } result_t;

endpackage

// ===== sv/typed_key_value_table_top.sv =====
// Typed key-value table with in-order linear search. A set or find walks the
// filled entries one per cycle through a single read port of the entry
// memory; a clear or an unused operation code goes straight to the done
// state. One item is worked on at a time; the finished result waits in an
// output register so the next item can be taken before it is collected. A
// set of a new key into a full table is dropped and reported as table_full.
// The entry memory needs no clearing after reset: only entries below the
// count are ever read.
module typed_key_value_table_top #(
  parameter int unsigned MAX_ENTRIES = kvt_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned KEY_BITS    = kvt_pkg::KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // operation[1:0], key[17:2], value[81:18], zero pad
  input  logic [2:0]  s_tuser,   // value_type[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata    // found[0], read_value[64:1], table_full[65], zero pad
);
  import kvt_pkg::*;

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned EW = KEY_BITS + TYPE_W + VALUE_W;

  mem_cmd_t       mem_cmd;
  logic [AW-1:0]  rd_addr, wr_addr;
  logic [EW-1:0]  wr_data, rd_data;
  logic           res_valid, res_ready;
  result_t        res, out_res;

  kvt_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS),
    .AW          (AW),
    .EW          (EW)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_operation  (s_tdata[1:0]),
    .in_key        (s_tdata[17:2]),
    .in_value_type (s_tuser),
    .in_value      (s_tdata[81:18]),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .mem_cmd       (mem_cmd),
    .rd_addr       (rd_addr),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_data       (rd_data)
  );

  kvt_mem #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW),
    .EW    (EW)
  ) u_mem (
    .clk     (clk),
    .cmd     (mem_cmd),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_tdata = {6'b0, out_res.table_full, out_res.read_value, out_res.found};

endmodule

// ===== sv/kvt_mem.sv =====
module kvt_mem #(
  parameter int unsigned DEPTH = kvt_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned AW    = 6,
  parameter int unsigned EW    = 83
) (
  input  logic              clk,
  input  kvt_pkg::mem_cmd_t cmd,
  input  logic [AW-1:0]     rd_addr,
  input  logic [AW-1:0]     wr_addr,
  input  logic [EW-1:0]     wr_data,
  output logic [EW-1:0]     rd_data
);
  import kvt_pkg::*;

  logic [EW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/kvt_ctrl.sv =====
module kvt_ctrl #(
  parameter int unsigned MAX_ENTRIES = kvt_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned KEY_BITS    = kvt_pkg::KEY_BITS_DEF,
  parameter int unsigned AW          = 6,
  parameter int unsigned EW          = 83
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_operation,
  input  logic [kvt_pkg::KEY_W-1:0]     in_key,
  input  logic [kvt_pkg::TYPE_W-1:0]    in_value_type,
  input  logic [kvt_pkg::VALUE_W-1:0]   in_value,
  output logic                          res_valid,
  input  logic                          res_ready,
  output kvt_pkg::result_t              res,
  output kvt_pkg::mem_cmd_t             mem_cmd,
  output logic [AW-1:0]                 rd_addr,
  output logic [AW-1:0]                 wr_addr,
  output logic [EW-1:0]                 wr_data,
  input  logic [EW-1:0]                 rd_data
);
  import kvt_pkg::*;

  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

  state_t               state, state_next;
  op_t                  op, op_next;
  logic [KEY_BITS-1:0]  key, key_next;
  logic [TYPE_W-1:0]    vtype, vtype_next;
  logic [VALUE_W-1:0]   value, value_next;
  logic [CW-1:0]        idx, idx_next;
  logic [CW-1:0]        cnt, cnt_next;
  logic [AW-1:0]        rd_idx, rd_idx_next;
  logic                 rd_pend, rd_pend_next;
  result_t              res_next;

  logic [KEY_BITS-1:0]  rd_key;
  logic [TYPE_W-1:0]    rd_type;
  logic [VALUE_W-1:0]   rd_value;
  logic                 hit;

  assign {rd_key, rd_type, rd_value} = rd_data;
  assign wr_data  = {key, vtype, value};
  assign rd_addr  = idx[AW-1:0];
  assign in_ready = (state == ST_IDLE);
  // read data of the previous beat is compared while the next read is issued
  assign hit      = rd_pend && (rd_key == key);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cnt     <= '0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      rd_pend <= rd_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    op     <= op_next;
    key    <= key_next;
    vtype  <= vtype_next;
    value  <= value_next;
    idx    <= idx_next;
    rd_idx <= rd_idx_next;
    res    <= res_next;
  end

  always_comb begin
    state_next   = state;
    op_next      = op;
    key_next     = key;
    vtype_next   = vtype;
    value_next   = value;
    idx_next     = idx;
    cnt_next     = cnt;
    rd_idx_next  = rd_idx;
    rd_pend_next = 1'b0;
    res_next     = res;
    mem_cmd      = '0;
    wr_addr      = rd_idx;
    res_valid    = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          op_next    = op_t'(in_operation);
          key_next   = KEY_BITS'(in_key);
          vtype_next = in_value_type;
          value_next = in_value;
          idx_next   = '0;
          res_next   = '0;
          case (op_t'(in_operation))
            OP_SET, OP_FIND: state_next = ST_SCAN;
            OP_CLEAR: begin
              cnt_next   = '0;
              state_next = ST_DONE;
            end
            default: state_next = ST_DONE;
          endcase
        end
      end

      ST_SCAN: begin
        priority if (hit) begin
          if (op == OP_SET) begin
            mem_cmd.wr = 1'b1;
            wr_addr    = rd_idx;
          end else if (rd_type == vtype) begin
            res_next.found      = 1'b1;
            res_next.read_value = rd_value;
          end
          state_next = ST_DONE;
        end else if (idx >= cnt) begin
          // whole filled range seen without a match
          if (op == OP_SET) begin
            if (cnt < MAX_CNT) begin
              mem_cmd.wr = 1'b1;
              wr_addr    = cnt[AW-1:0];
              cnt_next   = cnt + CW'(1);
            end else begin
              res_next.table_full = 1'b1;
            end
          end
          state_next = ST_DONE;
        end else begin
          mem_cmd.rd   = 1'b1;
          rd_idx_next  = idx[AW-1:0];
          rd_pend_next = 1'b1;
          idx_next     = idx + CW'(1);
        end
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= MAX_CNT)
    else $error("entry count beyond table size");

  a_pend_scan: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> state == ST_SCAN)
    else $error("read pending outside search");

  a_wr_dense: assert property (@(posedge clk) disable iff (rst)
    mem_cmd.wr |-> ({1'b0, wr_addr} <= {1'b0, cnt}) && !mem_cmd.rd)
    else $error("write leaves a gap in the table");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_operation == OP_CLEAR) |=> cnt == '0)
    else $error("clear did not empty the table");

  a_res_only_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |=> !(mem_cmd.wr && $past(mem_cmd.wr)))
    else $error("double write for one item");

endmodule

// ===== dv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import kvt_pkg::*;

  localparam int unsigned DEPTH        = MAX_ENTRIES_DEF;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam logic [2:0]  VT_INT32     = 3'd0;
  localparam logic [2:0]  VT_INT64     = 3'd1;
  localparam logic [2:0]  VT_SIZE      = 3'd2;
  localparam logic [2:0]  VT_FLOAT     = 3'd3;
  localparam logic [2:0]  VT_DOUBLE    = 3'd4;
  localparam logic [2:0]  VT_POINTER   = 3'd5;
  localparam logic [2:0]  VT_SPARE_LO  = 3'd6;
  localparam logic [2:0]  VT_SPARE_HI  = 3'd7;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned HOLD_CYCLES  = 400;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [87:0] s_tdata;   // operation[1:0], key[17:2], value[81:18], zero pad
  logic [2:0]  s_tuser;   // value_type[2:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;   // found[0], read_value[64:1], table_full[65], zero pad

  typed_key_value_table_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // table mirror
  logic [KEY_W-1:0]   tbl_key   [DEPTH];
  logic [TYPE_W-1:0]  tbl_type  [DEPTH];
  logic [VALUE_W-1:0] tbl_value [DEPTH];
  int unsigned        tbl_count;

  result_t     pending_results [$];
  int unsigned errors;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned hold_req;
  int unsigned hold_left;
  int unsigned quiet_cycles;

  function automatic result_t lookup_or_store(logic [1:0] op, logic [KEY_W-1:0] key,
                                              logic [TYPE_W-1:0] vt,
                                              logic [VALUE_W-1:0] value);
    result_t     res;
    int unsigned idx;
    res = '0;
    idx = 0;
    // first entry with the key wins; later duplicates never exist anyway
    while (idx < tbl_count && tbl_key[idx] != key) idx++;
    case (op)
      OP_SET: begin
        if (idx < tbl_count) begin
          tbl_type[idx]  = vt;
          tbl_value[idx] = value;
        end else if (tbl_count < DEPTH) begin
          tbl_key[tbl_count]   = key;
          tbl_type[tbl_count]  = vt;
          tbl_value[tbl_count] = value;
          tbl_count++;
        end else begin
          res.table_full = 1'b1;
        end
      end
      OP_FIND: begin
        if (idx < tbl_count && tbl_type[idx] == vt) begin
          res.found      = 1'b1;
          res.read_value = tbl_value[idx];
        end
      end
      OP_CLEAR: begin
        tbl_count = 0;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      pending_results.push_back(lookup_or_store(s_tdata[1:0], s_tdata[17:2], s_tuser,
                                                s_tdata[81:18]));
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[65:0];
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, found %0b read_value %h table_full %0b",
                 $time, got.found, got.read_value, got.table_full);
      end else begin
        want = pending_results.pop_front();
        if (got.found != want.found || got.read_value != want.read_value ||
            got.table_full != want.table_full) begin
          errors++;
          $display("%0t: mismatch, expected found %0b read_value %h table_full %0b,",
                   $time, want.found, want.read_value, want.table_full);
          $display("%0t:           got found %0b read_value %h table_full %0b",
                   $time, got.found, got.read_value, got.table_full);
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_item(logic [1:0] op, logic [KEY_W-1:0] key, logic [TYPE_W-1:0] vt,
                           logic [VALUE_W-1:0] value);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, value, key, op};
    s_tuser  <= vt;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic test_basic_access();
    send_item(OP_FIND,  16'h0000, VT_INT32,    '1);        // empty table
    send_item(OP_SET,   16'h0000, VT_INT32,    '0);
    send_item(OP_SET,   16'hffff, VT_SPARE_HI, '1);
    send_item(OP_FIND,  16'hffff, VT_SPARE_HI, '0);
    send_item(OP_FIND,  16'hffff, VT_SPARE_LO, '0);        // wrong type
    send_item(OP_FIND,  16'h0000, VT_INT32,    64'h5555_5555_5555_5555);
    send_item(OP_SET,   16'h0000, VT_POINTER,  64'haaaa_aaaa_aaaa_aaaa);
    send_item(OP_FIND,  16'h0000, VT_POINTER,  '0);
    send_item(OP_FIND,  16'h0000, VT_INT32,    '0);
    send_item(OP_SET,   16'h5a5a, VT_SPARE_LO, 64'h5555_5555_5555_5555);
    send_item(OP_SET,   16'ha5a5, VT_INT64,    64'h8000_0000_0000_0001);
    send_item(OP_SET,   16'h1234, VT_SIZE,     64'h0123_4567_89ab_cdef);
    send_item(OP_SET,   16'h4321, VT_FLOAT,    64'h0000_0000_3f80_0000);
    send_item(OP_SET,   16'h7777, VT_DOUBLE,   64'h3ff0_0000_0000_0000);
    send_item(OP_FIND,  16'h5a5a, VT_SPARE_LO, '0);
    send_item(OP_FIND,  16'h7777, VT_DOUBLE,   '0);
    send_item(OP_FIND,  16'h9999, VT_DOUBLE,   '0);        // absent key
    send_item(OP_UNUSED, 16'h7777, VT_DOUBLE,  '1);
    send_item(OP_FIND,  16'h7777, VT_DOUBLE,   '0);
    send_item(OP_CLEAR, 16'h7777, VT_DOUBLE,   '1);
    send_item(OP_FIND,  16'h7777, VT_DOUBLE,   '0);
    send_item(OP_SET,   16'h7777, VT_INT32,    64'hdead_beef_0000_ffff);
    send_item(OP_FIND,  16'h7777, VT_INT32,    '0);
  endtask

  task automatic test_fill_to_capacity();
    logic [KEY_W-1:0] base;
    base = KEY_W'($urandom_range(0, 65535 - 2 * DEPTH));
    send_item(OP_CLEAR, '0, VT_INT32, '0);
    for (int i = 0; i < DEPTH; i++)
      send_item(OP_SET, KEY_W'(base + i), TYPE_W'($urandom_range(7)), rand_value());
    send_item(OP_SET, KEY_W'(base + DEPTH + $urandom_range(DEPTH - 1)), VT_INT64,
              '1);                                                      // dropped
    send_item(OP_FIND, KEY_W'(base + DEPTH), VT_INT64, '0);             // full miss
    send_item(OP_SET,  KEY_W'(base + DEPTH - 1), VT_SPARE_LO, 64'h0f0f_0f0f_f0f0_f0f0);
    send_item(OP_FIND, KEY_W'(base + DEPTH - 1), VT_SPARE_LO, '0);
    send_item(OP_FIND, base, VT_SPARE_HI, '0);
    send_item(OP_CLEAR, '0, VT_INT32, '0);
    send_item(OP_SET,  KEY_W'(base + DEPTH), VT_INT64, '1);
    send_item(OP_FIND, KEY_W'(base + DEPTH), VT_INT64, '0);
  endtask

  // receiver stops for a long stretch; the block must fill and drop s_tready
  task automatic test_output_backpressure();
    hold_req = HOLD_CYCLES;
    @(posedge clk);
    @(negedge clk);
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 2)
        send_item(OP_FIND, KEY_W'(16'h0100 + i - 1), VT_FLOAT, '0);
      else
        send_item(OP_SET, KEY_W'(16'h0100 + i), VT_FLOAT, rand_value());
    end
  endtask

  task automatic test_random_sessions(int unsigned budget);
    int unsigned      sent;
    int unsigned      len;
    int unsigned      pool_n;
    int unsigned      pick;
    logic [KEY_W-1:0] pool [$];
    logic [KEY_W-1:0] key;
    logic [2:0]       vt;
    bit [2:0]         last_type [bit [15:0]];
    sent = 0;
    while (sent < budget) begin
      case (sent * 3 / budget)
        0:       begin src_idle_pct = 24; sink_idle_pct = 57; end
        1:       begin src_idle_pct = 57; sink_idle_pct = 24; end
        default: begin src_idle_pct = 0;  sink_idle_pct = 0;  end
      endcase
      // a big key pool now and then drives the table into the full state
      if ($urandom_range(3) == 0) begin
        pool_n = $urandom_range(70, 100);
        len    = 3 * pool_n;
      end else begin
        pool_n = $urandom_range(2, 40);
        len    = $urandom_range(10, 4 * pool_n);
      end
      pool.delete();
      repeat (pool_n) begin
        case ($urandom_range(19))
          0:       pool.push_back(16'h0000);
          1:       pool.push_back(16'hffff);
          default: pool.push_back(KEY_W'($urandom_range(65535)));
        endcase
      end
      last_type.delete();
      send_item(OP_CLEAR, KEY_W'($urandom_range(65535)), TYPE_W'($urandom_range(7)),
                rand_value());
      sent++;
      if (len > budget - sent) len = budget - sent;
      repeat (len) begin
        pick = $urandom_range(99);
        key  = pool[$urandom_range(pool_n - 1)];
        vt   = TYPE_W'($urandom_range(7));
        if (pick < 48) begin
          send_item(OP_SET, key, vt, rand_value());
          last_type[key] = vt;
        end else if (pick < 92) begin
          if (last_type.exists(key) && $urandom_range(3) != 0) vt = last_type[key];
          send_item(OP_FIND, key, vt, rand_value());
        end else if (pick < 96) begin
          send_item(OP_FIND, KEY_W'($urandom_range(65535)), vt, rand_value());
        end else if (pick < 98) begin
          send_item(OP_CLEAR, key, vt, rand_value());
          last_type.delete();
        end else begin
          send_item(OP_UNUSED, key, vt, rand_value());
        end
        sent++;
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = '0;
    m_tready      = 1'b0;
    tbl_count     = 0;
    errors        = 0;
    hold_req      = 0;
    hold_left     = 0;
    quiet_cycles  = 0;
    src_idle_pct  = 24;
    sink_idle_pct = 57;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_basic_access();
    test_fill_to_capacity();
    test_output_backpressure();
    test_random_sessions(1040);

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== typed_key_value_table_top.f =====
sv/kvt_pkg.sv
sv/kvt_mem.sv
sv/kvt_ctrl.sv
sv/typed_key_value_table_top.sv
dv/testbench.sv
